### hw/rtl/bcl_pkg.sv
// Shared types and constants for the button code lock.
`default_nettype none
package bcl_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned SW_W   = 3;
	localparam int unsigned DEB_W  = 16;
	localparam int unsigned TICK_W = 20;
	localparam int unsigned IDX_W  = 2;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
	localparam logic [IDX_W-1:0] REG_IDLE_CLEAR = 2'd1;
	localparam logic [IDX_W-1:0] REG_HOLD       = 2'd2;

	localparam logic [DEB_W-1:0]  DEBOUNCE_RST   = 16'd50;
	localparam logic [TICK_W-1:0] IDLE_CLEAR_RST = 20'd15000;
	localparam logic [TICK_W-1:0] HOLD_RST       = 20'd3000;
	localparam logic [31:0]       CODE_RST       = 32'd246;

	// switch numbers
	localparam logic [SW_W-1:0] SW_ZERO       = 3'd1;
	localparam logic [SW_W-1:0] SW_ONE        = 3'd2;
	localparam logic [SW_W-1:0] SW_HOLD_END   = 3'd3;
	localparam logic [SW_W-1:0] SW_HOLD_START = 3'd4;

	// mode codes
	localparam logic [1:0] MODE_ENTRY = 2'd0;
	localparam logic [1:0] MODE_HOLD  = 2'd1;
	localparam logic [1:0] MODE_PROG  = 2'd2;

	// signal codes
	localparam logic [1:0] SIG_NONE    = 2'd0;
	localparam logic [1:0] SIG_UNLOCK  = 2'd1;
	localparam logic [1:0] SIG_PROG    = 2'd2;
	localparam logic [1:0] SIG_NEWCODE = 2'd3;

	// classified event handed from front to back
	typedef struct packed {
		logic [TIME_W-1:0] evt_time;
		logic [SW_W-1:0]   sw;
		logic              pass;   // cleared the debounce gap
		logic              idle;   // gap long enough to clear entered bits
	} evt_t;

endpackage
`default_nettype wire

### hw/rtl/bcl_front.sv
// Front end: accepts events, tracks last event time and classifies the gap.
`default_nettype none
module bcl_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire logic                        q_full,
	input  wire logic [bcl_pkg::TIME_W-1:0]  event_time,
	input  wire logic [bcl_pkg::SW_W-1:0]    switch_id,
	input  wire logic [bcl_pkg::DEB_W-1:0]   debounce_ticks,
	input  wire logic [bcl_pkg::TICK_W-1:0]  idle_clear_ticks,
	output logic                             in_stall,
	output logic                             push,
	output bcl_pkg::evt_t                    push_evt
);

	logic [bcl_pkg::TIME_W-1:0] last_time_q;
	logic [bcl_pkg::TIME_W-1:0] gap;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;
	// wraps modulo 2^32
	assign gap      = event_time - last_time_q;

	always_comb begin
		push_evt.evt_time = event_time;
		push_evt.sw       = switch_id;
		push_evt.pass     = gap >= bcl_pkg::TIME_W'(debounce_ticks);
		push_evt.idle     = gap >= bcl_pkg::TIME_W'(idle_clear_ticks);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
		end else if (push) begin
			last_time_q <= event_time;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/bcl_queue.sv
// Two-entry queue between front and back.
`default_nettype none
module bcl_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire bcl_pkg::evt_t push_evt,
	input  wire logic          pop,
	output logic               full,
	output logic               not_empty,
	output bcl_pkg::evt_t      head
);

	bcl_pkg::evt_t mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign full      = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_evt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

### hw/rtl/bcl_back.sv
// Back end: lock state machine, code storage and the result register.
`default_nettype none
module bcl_back #(
	parameter int unsigned CODE_BITS = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_not_empty,
	input  wire bcl_pkg::evt_t               head,
	input  wire logic [bcl_pkg::TICK_W-1:0]  hold_ticks,
	input  wire logic                        out_stall,
	output logic                             pop,
	output logic                             out_valid,
	output logic                             accepted,
	output logic [1:0]                       signal,
	output logic [1:0]                       mode_now
);

	localparam int unsigned CNT_W = $clog2(CODE_BITS);

	typedef enum logic [1:0] {
		ENTRY = bcl_pkg::MODE_ENTRY,
		HOLD  = bcl_pkg::MODE_HOLD,
		PROG  = bcl_pkg::MODE_PROG
	} mode_t;

	mode_t                       mode_q, mode_d;
	logic [CODE_BITS-1:0]        code_q, code_d;
	logic [CODE_BITS-1:0]        entered_q, entered_d;
	logic [CNT_W-1:0]            cnt_q, cnt_d;
	logic [bcl_pkg::TIME_W-1:0]  hold_start_q;
	logic                        hold_wr;
	logic [1:0]                  sig_d;
	logic [bcl_pkg::TIME_W-1:0]  held;
	logic                        held_long;
	logic                        is_digit;
	logic                        digit_val;
	logic [CODE_BITS-1:0]        base;
	logic [CODE_BITS-1:0]        shifted;

	assign pop       = q_not_empty && (!out_valid || !out_stall);
	assign held      = head.evt_time - hold_start_q;
	assign held_long = held >= bcl_pkg::TIME_W'(hold_ticks);
	assign is_digit  = head.sw == bcl_pkg::SW_ZERO || head.sw == bcl_pkg::SW_ONE;
	assign digit_val = head.sw == bcl_pkg::SW_ONE;
	assign base      = head.idle ? '0 : entered_q;
	assign shifted   = {base[CODE_BITS-2:0], digit_val};

	always_comb begin
		mode_d    = mode_q;
		code_d    = code_q;
		entered_d = entered_q;
		cnt_d     = cnt_q;
		hold_wr   = 1'b0;
		sig_d     = bcl_pkg::SIG_NONE;
		if (head.pass) begin
			case (mode_q)
				HOLD: begin
					if (head.sw == bcl_pkg::SW_HOLD_END) begin
						if (!held_long) begin
							mode_d = ENTRY;
						end
					end else if (held_long) begin
						mode_d = PROG;
						sig_d  = bcl_pkg::SIG_PROG;
					end
				end
				PROG: begin
					if (is_digit) begin
						code_d = {code_q[CODE_BITS-2:0], digit_val};
						if (cnt_q == CNT_W'(CODE_BITS - 1)) begin
							cnt_d  = '0;
							mode_d = ENTRY;
							sig_d  = bcl_pkg::SIG_NEWCODE;
						end else begin
							cnt_d = cnt_q + CNT_W'(1);
						end
					end
				end
				default: begin
					mode_d    = ENTRY;
					entered_d = base;
					if (is_digit) begin
						entered_d = shifted;
						if (shifted == code_q) begin
							sig_d = bcl_pkg::SIG_UNLOCK;
						end
					end else if (head.sw == bcl_pkg::SW_HOLD_START) begin
						mode_d  = HOLD;
						hold_wr = 1'b1;
					end
				end
			endcase
		end
	end

	// hold start has no reset value: it is always written before hold mode
	always_ff @(posedge clk) begin
		if (pop && hold_wr) begin
			hold_start_q <= head.evt_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= ENTRY;
			code_q    <= CODE_BITS'(bcl_pkg::CODE_RST);
			entered_q <= '0;
			cnt_q     <= '0;
			out_valid <= 1'b0;
			accepted  <= 1'b0;
			signal    <= bcl_pkg::SIG_NONE;
			mode_now  <= bcl_pkg::MODE_ENTRY;
		end else begin
			if (pop) begin
				mode_q    <= mode_d;
				code_q    <= code_d;
				entered_q <= entered_d;
				cnt_q     <= cnt_d;
				out_valid <= 1'b1;
				accepted  <= head.pass;
				signal    <= sig_d;
				mode_now  <= mode_d;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/button_code_lock.sv
// Button code lock top level: config registers, front, queue and back.
//
// Input channel: event_time and switch_id, one event per beat taken when
// in_valid is high and in_stall is low. Output channel: one result beat per
// event (accepted, signal, mode_now), taken when out_valid is high and
// out_stall is low. Config channel: cfg_index selects debounce (0), idle
// clear (1) or hold (2) ticks; cfg_ready is always high, other indexes are
// dropped. Write config only while no event is in flight.
// Each input beat passes a queue entry, then the result register; one event
// per cycle is sustained while out_stall is low. The front registers the
// last event time and classifies the gap, a two-entry queue decouples it
// from the back, which updates the lock state and holds the result register.
// A stalled result holds; the queue fills behind it and in_stall rises once
// both entries are used. Reset clears the queue and the result register and
// restores the default code, entry mode and the default tick settings.
`default_nettype none
module button_code_lock #(
	parameter int unsigned CODE_BITS = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [bcl_pkg::TIME_W-1:0]  event_time,
	input  wire logic [bcl_pkg::SW_W-1:0]    switch_id,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             accepted,
	output logic [1:0]                       signal,
	output logic [1:0]                       mode_now,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [bcl_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [bcl_pkg::TICK_W-1:0]  cfg_data
);

	logic [bcl_pkg::DEB_W-1:0]  debounce_q;
	logic [bcl_pkg::TICK_W-1:0] idle_clear_q;
	logic [bcl_pkg::TICK_W-1:0] hold_q;
	logic                       q_full;
	logic                       q_not_empty;
	logic                       push;
	logic                       pop;
	bcl_pkg::evt_t              push_evt;
	bcl_pkg::evt_t              head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= bcl_pkg::DEBOUNCE_RST;
			idle_clear_q <= bcl_pkg::IDLE_CLEAR_RST;
			hold_q       <= bcl_pkg::HOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bcl_pkg::REG_DEBOUNCE:   debounce_q   <= cfg_data[bcl_pkg::DEB_W-1:0];
				bcl_pkg::REG_IDLE_CLEAR: idle_clear_q <= cfg_data;
				bcl_pkg::REG_HOLD:       hold_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	bcl_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.q_full           (q_full),
		.event_time       (event_time),
		.switch_id        (switch_id),
		.debounce_ticks   (debounce_q),
		.idle_clear_ticks (idle_clear_q),
		.in_stall         (in_stall),
		.push             (push),
		.push_evt         (push_evt)
	);

	bcl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_evt  (push_evt),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head)
	);

	bcl_back #(
		.CODE_BITS (CODE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.head        (head),
		.hold_ticks  (hold_q),
		.out_stall   (out_stall),
		.pop         (pop),
		.out_valid   (out_valid),
		.accepted    (accepted),
		.signal      (signal),
		.mode_now    (mode_now)
	);

endmodule
`default_nettype wire

### hw/rtl/bcl_checker.sv
// Port-level checks for the button code lock, bound to the top level.
`default_nettype none
module bcl_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       accepted,
	input wire logic [1:0] signal,
	input wire logic [1:0] mode_now
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable({accepted, signal, mode_now}))
		else $error("result beat changed while stalled");

	// a debounced-away event never signals
	a_reject_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> signal == bcl_pkg::SIG_NONE)
		else $error("rejected event carries a signal");

	a_prog_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && signal == bcl_pkg::SIG_PROG |-> mode_now == bcl_pkg::MODE_PROG)
		else $error("programming signal outside programming mode");

	a_entry_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (signal == bcl_pkg::SIG_UNLOCK || signal == bcl_pkg::SIG_NEWCODE)
		|-> mode_now == bcl_pkg::MODE_ENTRY)
		else $error("unlock or new code outside entry mode");

endmodule

bind button_code_lock bcl_checker u_bcl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.accepted  (accepted),
	.signal    (signal),
	.mode_now  (mode_now)
);
`default_nettype wire

### sim/button_code_lock_checker.sv
// Scoreboard for the button code lock: predicts each result beat and compares it.
`timescale 1ns / 100ps

module button_code_lock_checker #(
	parameter int unsigned CODE_BITS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [bcl_pkg::TIME_W-1:0] event_time,
	input  logic [bcl_pkg::SW_W-1:0]   switch_id,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic                       accepted,
	input  logic [1:0]                 signal,
	input  logic [1:0]                 mode_now,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [bcl_pkg::IDX_W-1:0]  cfg_index,
	input  logic [bcl_pkg::TICK_W-1:0] cfg_data,
	output int                         mismatches,
	output int                         pending
);

	localparam logic [31:0] CODE_MASK = 32'((64'd1 << CODE_BITS) - 64'd1);

	typedef struct packed {
		logic       accepted;
		logic [1:0] signal;
		logic [1:0] mode;
	} lock_result_t;

	lock_result_t lock_results_due[$];
	int fail_count = 0;
	int due_count  = 0;

	// lock state as the block should hold it
	logic [bcl_pkg::TIME_W-1:0] last_time_q;
	logic [bcl_pkg::TIME_W-1:0] hold_start_q;
	logic [31:0]                code_q;
	logic [31:0]                entered_q;
	logic [1:0]                 mode_q;
	int unsigned                digits_q;
	logic [bcl_pkg::DEB_W-1:0]  debounce_q;
	logic [bcl_pkg::TICK_W-1:0] idle_clear_q;
	logic [bcl_pkg::TICK_W-1:0] hold_q;

	assign mismatches = fail_count;
	assign pending    = due_count;

	function automatic lock_result_t lock_step(input logic [bcl_pkg::TIME_W-1:0] t,
			input logic [bcl_pkg::SW_W-1:0] sw);
		logic [31:0]  gap;
		logic [31:0]  held;
		lock_result_t r;
		gap  = t - last_time_q;
		held = t - hold_start_q;
		r    = '{accepted: 1'b0, signal: bcl_pkg::SIG_NONE, mode: bcl_pkg::MODE_ENTRY};
		last_time_q = t;
		if (gap >= 32'(debounce_q)) begin
			r.accepted = 1'b1;
			case (mode_q)
			bcl_pkg::MODE_HOLD: begin
				if (sw == bcl_pkg::SW_HOLD_END) begin
					// released late: stays in hold
					if (held < 32'(hold_q))
						mode_q = bcl_pkg::MODE_ENTRY;
				end else if (held >= 32'(hold_q)) begin
					mode_q   = bcl_pkg::MODE_PROG;
					r.signal = bcl_pkg::SIG_PROG;
				end
			end
			bcl_pkg::MODE_PROG: begin
				if (sw == bcl_pkg::SW_ZERO || sw == bcl_pkg::SW_ONE) begin
					code_q = ((code_q << 1) | 32'(sw == bcl_pkg::SW_ONE)) & CODE_MASK;
					digits_q++;
					if (digits_q >= CODE_BITS) begin
						digits_q = 0;
						mode_q   = bcl_pkg::MODE_ENTRY;
						r.signal = bcl_pkg::SIG_NEWCODE;
					end
				end
			end
			default: begin
				mode_q = bcl_pkg::MODE_ENTRY;
				if (gap >= 32'(idle_clear_q))
					entered_q = '0;
				if (sw == bcl_pkg::SW_ZERO || sw == bcl_pkg::SW_ONE) begin
					entered_q = ((entered_q << 1) | 32'(sw == bcl_pkg::SW_ONE)) & CODE_MASK;
					if (entered_q == code_q)
						r.signal = bcl_pkg::SIG_UNLOCK;
				end else if (sw == bcl_pkg::SW_HOLD_START) begin
					mode_q       = bcl_pkg::MODE_HOLD;
					hold_start_q = t;
				end
			end
			endcase
		end
		r.mode = mode_q;
		return r;
	endfunction

	task automatic note_failure(input string what, input lock_result_t exp_r,
			input lock_result_t got_r);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s: exp acc=%0d sig=%0d mode=%0d, got acc=%0d sig=%0d mode=%0d",
				$time, what, exp_r.accepted, exp_r.signal, exp_r.mode,
				got_r.accepted, got_r.signal, got_r.mode);
	endtask

	always @(posedge clk or negedge arst_n) begin
		lock_result_t got_r;
		lock_result_t exp_r;
		if (!arst_n) begin
			last_time_q  = '0;
			hold_start_q = '0;
			code_q       = bcl_pkg::CODE_RST & CODE_MASK;
			entered_q    = '0;
			mode_q       = bcl_pkg::MODE_ENTRY;
			digits_q     = 0;
			debounce_q   = bcl_pkg::DEBOUNCE_RST;
			idle_clear_q = bcl_pkg::IDLE_CLEAR_RST;
			hold_q       = bcl_pkg::HOLD_RST;
			lock_results_due.delete();
			due_count    <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				bcl_pkg::REG_DEBOUNCE:   debounce_q   = cfg_data[bcl_pkg::DEB_W-1:0];
				bcl_pkg::REG_IDLE_CLEAR: idle_clear_q = cfg_data;
				bcl_pkg::REG_HOLD:       hold_q       = cfg_data;
				default:                 ;
				endcase
			end
			if (out_valid && !out_stall) begin
				got_r = '{accepted: accepted, signal: signal, mode: mode_now};
				if (lock_results_due.size() == 0) begin
					note_failure("result beat with nothing outstanding", '0, got_r);
				end else begin
					exp_r = lock_results_due.pop_front();
					if (got_r.accepted !== exp_r.accepted || got_r.signal !== exp_r.signal ||
							got_r.mode !== exp_r.mode)
						note_failure("result beat differs", exp_r, got_r);
				end
			end
			if (in_valid && !in_stall)
				lock_results_due.push_back(lock_step(event_time, switch_id));
			due_count <= lock_results_due.size();
		end
	end

endmodule

### sim/button_code_lock_tb.sv
// Testbench top for the button code lock: stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module button_code_lock_tb;

	localparam int unsigned CODE_BITS       = 8;
	localparam int          HOLD_OFF_CYCLES = 200;
	localparam int          DRAIN_LIMIT     = 20000;
	localparam int          PHASE_EVENTS    = 175;

	localparam logic [bcl_pkg::IDX_W-1:0] REG_UNUSED    = 2'd3;
	localparam logic [bcl_pkg::SW_W-1:0]  SW_UNUSED_LO  = 3'd0;
	localparam logic [bcl_pkg::SW_W-1:0]  SW_UNUSED_MID = 3'd6;
	localparam logic [bcl_pkg::SW_W-1:0]  SW_UNUSED_HI  = 3'd7;

	typedef enum int {
		GAP_BOUNCE,
		GAP_DIGIT,
		GAP_CLEAR,
		GAP_HELD,
		GAP_EARLY,
		GAP_WILD
	} gap_kind_t;

	typedef enum int {
		SEQ_UNLOCK,
		SEQ_PROGRAM,
		SEQ_CANCEL,
		SEQ_NOISE
	} seq_kind_t;

	logic                       clk        = 1'b0;
	logic                       arst_n     = 1'b0;
	logic                       in_valid   = 1'b0;
	logic                       in_stall;
	logic [bcl_pkg::TIME_W-1:0] event_time = '0;
	logic [bcl_pkg::SW_W-1:0]   switch_id  = '0;
	logic                       out_valid;
	logic                       out_stall  = 1'b0;
	logic                       accepted;
	logic [1:0]                 signal;
	logic [1:0]                 mode_now;
	logic                       cfg_valid  = 1'b0;
	logic                       cfg_ready;
	logic [bcl_pkg::IDX_W-1:0]  cfg_index  = '0;
	logic [bcl_pkg::TICK_W-1:0] cfg_data   = '0;

	int mismatches;
	int pending;

	// stimulus-side copy of the tick settings, used to shape the gaps
	logic [31:0] deb_ticks  = 32'(bcl_pkg::DEBOUNCE_RST);
	logic [31:0] idle_ticks = 32'(bcl_pkg::IDLE_CLEAR_RST);
	logic [31:0] hold_len   = 32'(bcl_pkg::HOLD_RST);

	logic [bcl_pkg::TIME_W-1:0] now_ticks = '0;
	logic [CODE_BITS-1:0]       code_guess;
	int                         burst_left    = 0;
	int                         sent_count    = 0;
	int                         hold_off_req  = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	button_code_lock #(
		.CODE_BITS(CODE_BITS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.event_time(event_time),
		.switch_id (switch_id),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.accepted  (accepted),
		.signal    (signal),
		.mode_now  (mode_now),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	button_code_lock_checker #(
		.CODE_BITS(CODE_BITS)
	) u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.event_time(event_time),
		.switch_id (switch_id),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.accepted  (accepted),
		.signal    (signal),
		.mode_now  (mode_now),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mismatches(mismatches),
		.pending   (pending)
	);

	function automatic logic [bcl_pkg::SW_W-1:0] digit_switch(input logic b);
		return b ? bcl_pkg::SW_ONE : bcl_pkg::SW_ZERO;
	endfunction

	function automatic logic [31:0] pick_gap(input gap_kind_t kind);
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] gap;
		case (kind)
		GAP_BOUNCE: begin
			gap = (deb_ticks == 0) ? 32'd0 : $urandom_range(deb_ticks - 1, 0);
		end
		GAP_DIGIT: begin
			// passes debounce but stays short of the idle clear where possible
			lo = deb_ticks;
			hi = (idle_ticks > deb_ticks) ? idle_ticks - 1 : deb_ticks;
			if (hi - lo > 2000)
				hi = lo + 2000;
			gap = $urandom_range(hi, lo);
		end
		GAP_CLEAR: begin
			lo  = (idle_ticks > deb_ticks) ? idle_ticks : deb_ticks;
			gap = lo + $urandom_range(500, 0);
		end
		GAP_HELD: begin
			lo  = (hold_len > deb_ticks) ? hold_len : deb_ticks;
			gap = lo + $urandom_range(500, 0);
		end
		GAP_EARLY: begin
			if (hold_len > deb_ticks) begin
				lo = deb_ticks;
				hi = hold_len - 1;
				if (hi - lo > 2000)
					hi = lo + 2000;
				gap = $urandom_range(hi, lo);
			end else begin
				gap = deb_ticks;
			end
		end
		default: begin
			gap = $urandom;
		end
		endcase
		return gap;
	endfunction

	// one input beat; the sender idles between bursts of random length
	task automatic offer_event(input logic [bcl_pkg::TIME_W-1:0] t,
			input logic [bcl_pkg::SW_W-1:0] sw);
		int idle_len;
		if (burst_left == 0) begin
			burst_left = $urandom_range(24, 1);
			idle_len   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
			if (idle_len != 0) begin
				in_valid <= 1'b0;
				repeat (idle_len) @(posedge clk);
			end
		end
		burst_left--;
		in_valid   <= 1'b1;
		event_time <= t;
		switch_id  <= sw;
		do @(posedge clk); while (in_stall);
		sent_count++;
	endtask

	task automatic send_at(input logic [bcl_pkg::TIME_W-1:0] t,
			input logic [bcl_pkg::SW_W-1:0] sw);
		now_ticks = t;
		offer_event(t, sw);
	endtask

	// an occasional contact bounce ahead of the intended event
	task automatic send_gap(input gap_kind_t kind, input logic [bcl_pkg::SW_W-1:0] sw);
		if (deb_ticks != 0 && $urandom_range(99, 0) < 6) begin
			now_ticks += pick_gap(GAP_BOUNCE);
			offer_event(now_ticks, bcl_pkg::SW_W'($urandom_range(7, 0)));
		end
		now_ticks += pick_gap(kind);
		offer_event(now_ticks, sw);
	endtask

	task automatic write_reg(input logic [bcl_pkg::IDX_W-1:0] idx,
			input logic [bcl_pkg::TICK_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
		bcl_pkg::REG_DEBOUNCE:   deb_ticks  = 32'(data[bcl_pkg::DEB_W-1:0]);
		bcl_pkg::REG_IDLE_CLEAR: idle_ticks = 32'(data);
		bcl_pkg::REG_HOLD:       hold_len   = 32'(data);
		default:                 ;
		endcase
	endtask

	task automatic wait_idle();
		in_valid  <= 1'b0;
		burst_left = 0;
		for (int n = 0; n < DRAIN_LIMIT && pending != 0; n++)
			@(negedge clk);
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic run_directed();
		logic [7:0] digits;
		digits = 8'hF6;
		send_at(32'd0, bcl_pkg::SW_ZERO);          // bounce right after reset
		send_at(32'hFFFF_FFFF, bcl_pkg::SW_ONE);   // long gap clears, first digit of the code
		send_at(32'd100, bcl_pkg::SW_ONE);         // time wrapped
		for (int i = 5; i >= 0; i--)
			send_at(32'(200 + 100 * (5 - i)), digit_switch(digits[i]));
		send_at(32'd720, bcl_pkg::SW_ONE);         // bounce, ignored
		send_at(32'd800, SW_UNUSED_HI);            // unused switch in entry
		send_at(32'd1000, bcl_pkg::SW_HOLD_START);
		send_at(32'd1100, bcl_pkg::SW_HOLD_END);   // released early
		send_at(32'd1200, bcl_pkg::SW_HOLD_START);
		send_at(32'd5000, bcl_pkg::SW_HOLD_END);   // released late, still holding
		send_at(32'd5100, SW_UNUSED_MID);          // enters programming
		send_at(32'd5300, SW_UNUSED_LO);           // ignored while programming
		digits = 8'h55;
		for (int i = 7; i >= 0; i--)
			send_at(32'(5400 + 100 * (7 - i)), digit_switch(digits[i]));
		send_at(32'd6300, bcl_pkg::SW_ZERO);       // shifts onto the kept entered bits
		send_at(32'd30000, bcl_pkg::SW_ONE);       // idle gap clears first
		code_guess = 8'h55;
	endtask

	task automatic run_random(input int count);
		int                       target;
		int                       flip;
		int                       pick;
		int                       n;
		logic                     late;
		logic [bcl_pkg::SW_W-1:0] sw;
		logic [CODE_BITS-1:0]     new_code;
		seq_kind_t                seq;
		target = sent_count + count;
		while (sent_count < target) begin
			pick = $urandom_range(99, 0);
			seq  = (pick < 30) ? SEQ_UNLOCK : (pick < 60) ? SEQ_PROGRAM :
				(pick < 75) ? SEQ_CANCEL : SEQ_NOISE;
			case (seq)
			SEQ_UNLOCK: begin
				flip = ($urandom_range(99, 0) < 15) ? $urandom_range(CODE_BITS - 1, 0) : -1;
				for (int i = CODE_BITS - 1; i >= 0; i--)
					send_gap((i == CODE_BITS - 1 && $urandom_range(1, 0) == 1) ?
						GAP_CLEAR : GAP_DIGIT, digit_switch(code_guess[i] ^ (i == flip)));
			end
			SEQ_PROGRAM: begin
				send_gap(GAP_DIGIT, bcl_pkg::SW_HOLD_START);
				late = ($urandom_range(2, 0) == 0);
				if (late)
					send_gap(GAP_HELD, bcl_pkg::SW_HOLD_END);
				do sw = bcl_pkg::SW_W'($urandom_range(7, 0));
				while (sw == bcl_pkg::SW_HOLD_END);
				send_gap(late ? GAP_DIGIT : GAP_HELD, sw);
				if ($urandom_range(3, 0) == 0) begin
					do sw = bcl_pkg::SW_W'($urandom_range(7, 0));
					while (sw == bcl_pkg::SW_ZERO || sw == bcl_pkg::SW_ONE);
					send_gap(GAP_DIGIT, sw);
				end
				new_code = CODE_BITS'($urandom);
				for (int i = CODE_BITS - 1; i >= 0; i--)
					send_gap(GAP_DIGIT, digit_switch(new_code[i]));
				code_guess = new_code;
			end
			SEQ_CANCEL: begin
				send_gap(GAP_DIGIT, bcl_pkg::SW_HOLD_START);
				send_gap(GAP_EARLY, bcl_pkg::SW_HOLD_END);
			end
			default: begin
				n = $urandom_range(4, 1);
				repeat (n)
					send_gap(gap_kind_t'($urandom_range(5, 0)),
						bcl_pkg::SW_W'($urandom_range(7, 0)));
			end
			endcase
		end
	endtask

	task automatic set_phase_config(input int phase);
		case (phase)
		0: begin
			write_reg(bcl_pkg::REG_DEBOUNCE, bcl_pkg::TICK_W'($urandom_range(200, 0)));
			write_reg(bcl_pkg::REG_IDLE_CLEAR, bcl_pkg::TICK_W'($urandom_range(6000, 300)));
			write_reg(bcl_pkg::REG_HOLD, bcl_pkg::TICK_W'($urandom_range(4000, 100)));
		end
		1: begin
			write_reg(bcl_pkg::REG_DEBOUNCE, '0);
			write_reg(bcl_pkg::REG_IDLE_CLEAR, '0);
			write_reg(bcl_pkg::REG_HOLD, '0);
		end
		2: begin
			write_reg(bcl_pkg::REG_DEBOUNCE, bcl_pkg::TICK_W'(16'hFFFF));
			write_reg(bcl_pkg::REG_IDLE_CLEAR, '1);
			write_reg(bcl_pkg::REG_HOLD, '1);
		end
		3: begin
			write_reg(bcl_pkg::REG_DEBOUNCE, bcl_pkg::TICK_W'($urandom_range(300, 1)));
			write_reg(REG_UNUSED, bcl_pkg::TICK_W'($urandom));   // dropped by the block
			write_reg(bcl_pkg::REG_IDLE_CLEAR, bcl_pkg::TICK_W'($urandom_range(20000, 500)));
			write_reg(bcl_pkg::REG_HOLD, bcl_pkg::TICK_W'($urandom_range(5000, 50)));
		end
		4: begin
			write_reg(bcl_pkg::REG_DEBOUNCE, '0);
			write_reg(bcl_pkg::REG_IDLE_CLEAR, '1);
			write_reg(bcl_pkg::REG_HOLD, bcl_pkg::TICK_W'($urandom_range(500, 0)));
		end
		default: begin
			write_reg(bcl_pkg::REG_DEBOUNCE, bcl_pkg::TICK_W'(bcl_pkg::DEBOUNCE_RST));
			write_reg(bcl_pkg::REG_IDLE_CLEAR, bcl_pkg::IDLE_CLEAR_RST);
			write_reg(bcl_pkg::REG_HOLD, bcl_pkg::HOLD_RST);
		end
		endcase
	endtask

	// receiver: random stall segments, plus a long hold-off on request
	initial begin : receiver
		int seg_left;
		int stall_pct;
		int served;
		seg_left  = 0;
		stall_pct = 0;
		served    = 0;
		forever begin
			@(posedge clk);
			if (served != hold_off_req) begin
				served = hold_off_req;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			if (seg_left == 0) begin
				seg_left = $urandom_range(80, 8);
				case ($urandom_range(4, 0))
				0, 1:    stall_pct = 0;
				2:       stall_pct = 30;
				3:       stall_pct = 60;
				default: stall_pct = 90;
				endcase
			end
			seg_left--;
			out_stall <= ($urandom_range(99, 0) < stall_pct);
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int phase = 0; phase < 6; phase++) begin
			wait_idle();
			set_phase_config(phase);
			if (phase == 0 || phase == 3)
				hold_off_req++;
			run_random(PHASE_EVENTS);
		end
		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("button_code_lock: match");
		else
			$display("button_code_lock: mismatch");
		$finish;
	end

	initial begin
		#2000000;
		$display("button_code_lock: mismatch");
		$finish;
	end

endmodule

### button_code_lock.f
hw/rtl/bcl_pkg.sv
hw/rtl/bcl_front.sv
hw/rtl/bcl_queue.sv
hw/rtl/bcl_back.sv
hw/rtl/button_code_lock.sv
hw/rtl/bcl_checker.sv
sim/button_code_lock_checker.sv
sim/button_code_lock_tb.sv
